@@ hdl/iols_pkg.sv @@
// shared types and constants for the indexed ordered list store
// no dependencies; used by iols_ram users and the top level
`default_nettype none

package iols_pkg;

    // number of list entries held in the entry memory
    localparam int DEPTH = 16;
    // entry memory address width
    localparam int IDX_W = $clog2(DEPTH);
    // field widths fixed by the port list
    localparam int CNT_W = 5;
    localparam int POS_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

endpackage

`default_nettype wire

@@ hdl/iols_ram.sv @@
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
`default_nettype none

module iols_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 4
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/indexed_ordered_list_store_unit.sv @@
// indexed ordered list store: top level, sequencer over the entry memory
// depends on iols_pkg and iols_ram
// sequencing: a bad, full or unused-op beat gives its done strobe in the cycle
// after start; a read passes through S_READ first; an insert or delete that
// moves n entries passes through S_SHIFT, where one memory port pair moves one
// entry per cycle. start is taken again once busy drops; the receiver cannot
// stall, each done beat is taken in its own cycle.
// reset: count and control clear at once; entry memory is not cleared.
`default_nettype none

module indexed_ordered_list_store_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [1:0]                       op,
    input  wire logic [iols_pkg::POS_W-1:0]       position,
    input  wire logic signed [iols_pkg::DATA_W-1:0] value_in,
    output logic                                  done,
    output logic [1:0]                            status,
    output logic signed [iols_pkg::DATA_W-1:0]    value_out,
    output logic [iols_pkg::CNT_W-1:0]            count_after
);

    // one-hot sequencer states
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SHIFT = 3'b010,
        S_READ  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // list length and shift bookkeeping
    logic [iols_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [iols_pkg::IDX_W-1:0]  idx_reg, idx_next;        // next entry to read
    logic [iols_pkg::CNT_W-1:0]  rem_reg, rem_next;        // entries left to move
    logic                        pend_reg, pend_next;      // read data waits for a write
    logic [iols_pkg::IDX_W-1:0]  pend_addr_reg, pend_addr_next;
    logic                        down_reg, down_next;      // insert moves toward the end
    logic [iols_pkg::IDX_W-1:0]  pos_reg, pos_next;
    logic [iols_pkg::DATA_W-1:0] val_reg, val_next;

    // result registers
    logic                        done_reg, done_next;
    iols_pkg::status_t           status_reg, status_next;
    logic [iols_pkg::DATA_W-1:0] value_reg, value_next;

    // memory port signals
    logic                        mem_we;
    logic [iols_pkg::IDX_W-1:0]  mem_waddr;
    logic [iols_pkg::DATA_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [iols_pkg::IDX_W-1:0]  mem_raddr;
    logic [iols_pkg::DATA_W-1:0] mem_rdata;

    logic accept;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    iols_ram #(
        .DATA_W (iols_pkg::DATA_W),
        .ADDR_W (iols_pkg::IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        down_next      = down_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        value_next     = value_reg;
        mem_we         = 1'b0;
        mem_waddr      = pend_addr_reg;
        mem_wdata      = mem_rdata;
        mem_re         = 1'b0;
        mem_raddr      = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pos_next   = position[iols_pkg::IDX_W-1:0];
                    val_next   = value_in;
                    pend_next  = 1'b0;
                    value_next = '0;
                    case (iols_pkg::op_t'(op))
                        iols_pkg::OP_INSERT:
                        begin
                            if (position > count_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = iols_pkg::ST_BAD_POS;
                            end
                            else if (count_reg == iols_pkg::CNT_W'(iols_pkg::DEPTH))
                            begin
                                done_next   = 1'b1;
                                status_next = iols_pkg::ST_FULL;
                            end
                            else
                            begin
                                // walk from the last entry back to position
                                down_next  = 1'b1;
                                idx_next   = iols_pkg::IDX_W'(count_reg - 1'b1);
                                rem_next   = count_reg - position;
                                state_next = S_SHIFT;
                            end
                        end
                        iols_pkg::OP_DELETE:
                        begin
                            if (position >= count_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = iols_pkg::ST_BAD_POS;
                            end
                            else
                            begin
                                // walk from the entry after position to the end
                                down_next  = 1'b0;
                                idx_next   = iols_pkg::IDX_W'(position + 1'b1);
                                rem_next   = count_reg - position - 1'b1;
                                state_next = S_SHIFT;
                            end
                        end
                        iols_pkg::OP_READ:
                        begin
                            if (position >= count_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = iols_pkg::ST_BAD_POS;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = position[iols_pkg::IDX_W-1:0];
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            // unused op: plain ok beat, list untouched
                            done_next   = 1'b1;
                            status_next = iols_pkg::ST_OK;
                        end
                    endcase
                end
            end

            S_SHIFT:
            begin
                // write port: pending move first, then the new value on insert
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                end
                else if (rem_reg == '0)
                begin
                    mem_we     = down_reg;
                    mem_waddr  = pos_reg;
                    mem_wdata  = val_reg;
                    done_next  = 1'b1;
                    status_next = iols_pkg::ST_OK;
                    count_next = down_reg ? count_reg + 1'b1 : count_reg - 1'b1;
                    state_next = S_IDLE;
                end

                // read port: fetch the next entry to move
                if (rem_reg != '0)
                begin
                    mem_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = down_reg ? mem_raddr + 1'b1 : mem_raddr - 1'b1;
                    idx_next       = down_reg ? idx_reg - 1'b1 : idx_reg + 1'b1;
                    rem_next       = rem_reg - 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            S_READ:
            begin
                value_next  = mem_rdata;
                status_next = iols_pkg::ST_OK;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // payload and bookkeeping, no reset needed
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        rem_reg       <= rem_next;
        pend_addr_reg <= pend_addr_next;
        down_reg      <= down_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        status_reg    <= status_next;
        value_reg     <= value_next;
    end

    // result beat: count_reg already reflects this operation while done is high
    assign done        = done_reg;
    assign status      = status_reg;
    assign value_out   = value_reg;
    assign count_after = count_reg;

`ifndef SYNTHESIS
    // list length never exceeds the memory depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= iols_pkg::CNT_W'(iols_pkg::DEPTH))
        else $error("list count above depth");

    // an accepted beat either finishes at once or keeps the unit busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (done_reg || busy))
        else $error("accepted beat dropped");

    // full status only when the list really is full
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == iols_pkg::ST_FULL)
            |-> count_reg == iols_pkg::CNT_W'(iols_pkg::DEPTH))
        else $error("full status on a list with room");

    // a nonzero read value only comes with an ok status
    a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && value_reg != '0) |-> status_reg == iols_pkg::ST_OK)
        else $error("value on a failed beat");
`endif

endmodule

`default_nettype wire
